[src/hsv_to_rgb_converter_defines.svh]
// assertion macros for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define HSVRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define HSVRGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSVRGB_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSVRGB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/hsvrgb_pkg.sv]
`timescale 1ns / 1ps
package hsvrgb_pkg;

  localparam int unsigned FRAC_BITS = 6;
  localparam int unsigned ONE_UNIT  = 1 << FRAC_BITS;
  localparam int unsigned FULL_PCT  = 100 * ONE_UNIT;
  localparam int unsigned SIXTY_DEG = 60 * ONE_UNIT;
  localparam int unsigned FULL_HUE  = 360 * ONE_UNIT;
  localparam int unsigned PCT_HUE   = FULL_PCT * SIXTY_DEG;

  localparam int unsigned HUE_W  = 15;
  localparam int unsigned PCT_W  = 13;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NUM_CH = 3;

  // per-lane widths
  localparam int unsigned K_W = $clog2(SIXTY_DEG + 1);
  localparam int unsigned P_W = $clog2(PCT_HUE + 1);
  localparam int unsigned N_W = PCT_W + P_W;

  // 255 / (100F * 100F * 60F) = 17 / (625 * 2^(3*FRAC_BITS+6))
  localparam int unsigned SCALE_MUL   = 17;
  localparam int unsigned SCALE_W     = N_W + 5;
  localparam int unsigned SCALE_SHIFT = 3 * FRAC_BITS + 6;

  // quotient before the divide by 625 is at most 255*625
  localparam int unsigned Q_W         = 18;
  localparam int unsigned RECIP       = 429497;   // ceil(2^28 / 625)
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned PROD_W      = Q_W + RECIP_W;

  localparam int unsigned LANE_R = 0;
  localparam int unsigned LANE_G = 1;
  localparam int unsigned LANE_B = 2;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            in_range;
  } rgb_out_t;

  // 60 degree hue sectors
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

endpackage

[src/hsv_to_rgb_converter.sv]
`timescale 1ns / 1ps
// HSV to RGB converter: one color per clock, fully pipelined. Hue comes in 1/64 degree,
// saturation and brightness in 1/64 percent. A transaction is taken at every edge with
// start high (busy is tied low, the pipe never stalls). Its result passes through the
// five register stages named below and shows on out_data with out_valid high for one cycle.
// Results keep the input order. The output side cannot push back, so the receiver
// must take every strobe. Hue above 360 degrees or saturation or brightness above 100
// percent gives in_range low and all channels zero. Hue of exactly 360 degrees gives
// the color of hue 0. Channels are truncated toward zero. Latency is set by the five
// register stages: sector decode, the s*k multiply, the brightness multiply, the 255
// scaling and the reciprocal multiply that replaces the divide by 625.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hsv_in_t  in_data,
  output logic     out_valid,
  output rgb_out_t out_data
);

  // every channel is floor(255 * b * (60F*100F - s*k) / (100F*100F*60F))
  // with k = 0 for the chroma channel, k = 60F for the zero channel
  // and k = distance from the hue to the middle of its 120 degree period for the second component

  // ---------------- stage 1: range check and sector decode
  logic                s1_valid_r;
  logic                s1_range_r, s1_range_nxt;
  logic [PCT_W-1:0]    s1_sat_r;
  logic [PCT_W-1:0]    s1_bri_r;
  logic [K_W-1:0]      s1_k_r   [NUM_CH];
  logic [K_W-1:0]      s1_k_nxt [NUM_CH];

  sector_t             sector;
  logic [HUE_W-1:0]    pair_base;
  logic [HUE_W-1:0]    hue_off;
  logic [K_W-1:0]      hue_dist;

  localparam logic [HUE_W-1:0] HUE_60  = HUE_W'(SIXTY_DEG);
  localparam logic [K_W-1:0]   K_FULL  = K_W'(SIXTY_DEG);
  localparam logic [K_W-1:0]   K_NONE  = '0;

  always_comb begin
    s1_range_nxt = (in_data.hue <= HUE_W'(FULL_HUE)) &&
                   (in_data.saturation <= PCT_W'(FULL_PCT)) &&
                   (in_data.brightness <= PCT_W'(FULL_PCT));

    // hue of exactly 360 degrees lands in the last sector
    priority if (in_data.hue < HUE_W'(SIXTY_DEG))     sector = SEC_RY;
    else if (in_data.hue < HUE_W'(2 * SIXTY_DEG))     sector = SEC_YG;
    else if (in_data.hue < HUE_W'(3 * SIXTY_DEG))     sector = SEC_GC;
    else if (in_data.hue < HUE_W'(4 * SIXTY_DEG))     sector = SEC_CB;
    else if (in_data.hue < HUE_W'(5 * SIXTY_DEG))     sector = SEC_BM;
    else                                              sector = SEC_MR;

    // start of the 120 degree period holding this hue
    unique case (sector)
      SEC_RY, SEC_YG: pair_base = '0;
      SEC_GC, SEC_CB: pair_base = HUE_W'(2 * SIXTY_DEG);
      default:        pair_base = HUE_W'(4 * SIXTY_DEG);
    endcase

    hue_off = in_data.hue - pair_base;
    if (hue_off >= HUE_60) begin
      hue_dist = K_W'(hue_off - HUE_60);
    end else begin
      hue_dist = K_W'(HUE_60 - hue_off);
    end

    // chroma -> K_NONE, second component -> hue_dist, zero -> K_FULL
    unique case (sector)
      SEC_RY: begin
        s1_k_nxt[LANE_R] = K_NONE;   s1_k_nxt[LANE_G] = hue_dist; s1_k_nxt[LANE_B] = K_FULL;
      end
      SEC_YG: begin
        s1_k_nxt[LANE_R] = hue_dist; s1_k_nxt[LANE_G] = K_NONE;   s1_k_nxt[LANE_B] = K_FULL;
      end
      SEC_GC: begin
        s1_k_nxt[LANE_R] = K_FULL;   s1_k_nxt[LANE_G] = K_NONE;   s1_k_nxt[LANE_B] = hue_dist;
      end
      SEC_CB: begin
        s1_k_nxt[LANE_R] = K_FULL;   s1_k_nxt[LANE_G] = hue_dist; s1_k_nxt[LANE_B] = K_NONE;
      end
      SEC_BM: begin
        s1_k_nxt[LANE_R] = hue_dist; s1_k_nxt[LANE_G] = K_FULL;   s1_k_nxt[LANE_B] = K_NONE;
      end
      default: begin
        s1_k_nxt[LANE_R] = K_NONE;   s1_k_nxt[LANE_G] = K_FULL;   s1_k_nxt[LANE_B] = hue_dist;
      end
    endcase
  end

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_range_r <= s1_range_nxt;
    s1_sat_r   <= in_data.saturation;
    s1_bri_r   <= in_data.brightness;
    s1_k_r     <= s1_k_nxt;
  end

  // ---------------- stage 2: p = 60F*100F - s*k
  logic                s2_valid_r;
  logic                s2_range_r;
  logic [PCT_W-1:0]    s2_bri_r;
  logic [P_W-1:0]      s2_p_r   [NUM_CH];
  logic [P_W-1:0]      s2_p_nxt [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s2_p_nxt[i] = P_W'(PCT_HUE) - (P_W'(s1_sat_r) * P_W'(s1_k_r[i]));
    end
  end

  // ---------------- stage 3: n = b * p
  logic                s3_valid_r;
  logic                s3_range_r;
  logic [N_W-1:0]      s3_n_r   [NUM_CH];
  logic [N_W-1:0]      s3_n_nxt [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s3_n_nxt[i] = N_W'(s2_bri_r) * N_W'(s2_p_r[i]);
    end
  end

  // ---------------- stage 4: q = floor(17 * n / 2^shift)
  logic                s4_valid_r;
  logic                s4_range_r;
  logic [Q_W-1:0]      s4_q_r   [NUM_CH];
  logic [Q_W-1:0]      s4_q_nxt [NUM_CH];
  logic [SCALE_W-1:0]  scaled   [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      scaled[i]   = SCALE_W'(s3_n_r[i]) * SCALE_W'(SCALE_MUL);
      s4_q_nxt[i] = scaled[i][SCALE_SHIFT +: Q_W];
    end
  end

  // ---------------- stage 5: channel = floor(q / 625), forced to zero out of range
  // the rounded-up reciprocal is exact for q below 2^28 / 169
  logic                out_valid_r;
  rgb_out_t            out_data_r, out_data_nxt;
  logic [PROD_W-1:0]   prod [NUM_CH];
  logic [CH_W-1:0]     chan [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      prod[i] = PROD_W'(s4_q_r[i]) * PROD_W'(RECIP);
      chan[i] = s4_range_r ? prod[i][RECIP_SHIFT +: CH_W] : '0;
    end
    out_data_nxt.red      = chan[LANE_R];
    out_data_nxt.green    = chan[LANE_G];
    out_data_nxt.blue     = chan[LANE_B];
    out_data_nxt.in_range = s4_range_r;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_range_r <= s1_range_r;
    s2_bri_r   <= s1_bri_r;
    s2_p_r     <= s2_p_nxt;
    s3_range_r <= s2_range_r;
    s3_n_r     <= s3_n_nxt;
    s4_range_r <= s3_range_r;
    s4_q_r     <= s4_q_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks
  `HSVRGB_ASSERT(a_valid_from_start, clk, rst_n, out_valid |-> $past(start, 5), "result without a transaction five edges earlier")
  `HSVRGB_ASSERT(a_zero_out_of_range, clk, rst_n, (out_valid && !out_data.in_range) |-> (out_data.red == '0 && out_data.green == '0 && out_data.blue == '0), "out of range result has nonzero channels")
  `HSVRGB_ASSERT(a_range_matches_hue, clk, rst_n, (out_valid && out_data.in_range) |-> $past(in_data.hue <= HUE_W'(FULL_HUE), 5), "in_range set for a hue above 360 degrees")
  `HSVRGB_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid, "result strobe right after reset")

endmodule
